### rtl/hlm_pkg.sv
`default_nettype none
package hlm_pkg;

   localparam int unsigned DefaultSlots = 16;
   localparam int unsigned TimeWidth    = 48;
   localparam int unsigned MsWidth      = 24;
   localparam int unsigned MaskWidth    = 16;
   localparam int unsigned CmdWidth     = 3;
   localparam int unsigned NodeWidth    = 4;
   localparam int unsigned EventWidth   = 3;
   localparam int unsigned CsrIdxWidth  = 3;
   localparam int unsigned CsrDataWidth = 24;

   // command codes
   localparam logic [CmdWidth-1:0] CMD_PING       = 3'd0;
   localparam logic [CmdWidth-1:0] CMD_ACK        = 3'd1;
   localparam logic [CmdWidth-1:0] CMD_SWEEP      = 3'd2;
   localparam logic [CmdWidth-1:0] CMD_REG_MASTER = 3'd3;
   localparam logic [CmdWidth-1:0] CMD_UNREG_MSTR = 3'd4;
   localparam logic [CmdWidth-1:0] CMD_REG_WORKER = 3'd5;

   // event codes
   localparam logic [EventWidth-1:0] EV_NONE        = 3'd0;
   localparam logic [EventWidth-1:0] EV_MASTER_LOST = 3'd1;
   localparam logic [EventWidth-1:0] EV_WORKER_LOST = 3'd2;
   localparam logic [EventWidth-1:0] EV_WORKER_CONN = 3'd3;
   localparam logic [EventWidth-1:0] EV_MASTER_CONN = 3'd4;
   localparam logic [EventWidth-1:0] EV_WORKER_REJ  = 3'd5;

   // configuration register indexes
   localparam logic [CsrIdxWidth-1:0] CSR_CHECK_INTERVAL = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_LEASE          = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_GRACE          = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_USE_ALLOW      = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CSR_ALLOW_MASK     = 3'd4;

   localparam logic [MsWidth-1:0] CHECK_INTERVAL_RESET = 24'd5000;
   localparam logic [MsWidth-1:0] LEASE_RESET          = 24'd9000;
   localparam logic [MsWidth-1:0] GRACE_RESET          = 24'd10000;

   typedef struct packed {
      logic [TimeWidth-1:0] ack_time;
      logic                 alive;
      logic                 rejected;
   } master_row_type;

   typedef struct packed {
      logic [TimeWidth-1:0] recv_time;
      logic                 alive;
   } worker_row_type;

endpackage
`default_nettype wire

### rtl/heartbeat_lease_monitor_top.sv
`default_nettype none
// heartbeat lease monitor: tracks masters and workers by slot number. a
// transaction is taken when start is high and busy is low. ping, ack,
// register and unregister commands read the slot tables as they are taken,
// then modify, write back and present the result in the exec state, so the
// block takes no new command before the last one is through. a check sweep
// walks the master table and then the worker table one slot per cycle through
// the memory read port and holds busy until its final result is registered.
// each result is shown for one cycle with rsp_strobe high and must be
// captured then: the receiver cannot stall the block. a sweep gives one
// result per lost master (ascending slot), then per lost worker, or a single
// empty result; rsp_last marks the final result of a transaction. csr writes
// must be made only while busy is low; the block itself does not enforce it.
module heartbeat_lease_monitor_top #(
   parameter int unsigned SLOTS = hlm_pkg::DefaultSlots
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // command channel
   input  wire logic                               start,
   output      logic                               busy,
   input  wire logic [hlm_pkg::CmdWidth-1:0]       req_cmd,
   input  wire logic [hlm_pkg::NodeWidth-1:0]      req_node,
   input  wire logic [hlm_pkg::TimeWidth-1:0]      req_now_ms,
   input  wire logic [hlm_pkg::TimeWidth-1:0]      req_beacon_time,
   input  wire logic                               req_ack_error,
   input  wire logic                               req_ack_allowed,
   input  wire logic                               req_ack_is_master,
   input  wire logic                               req_initial_alive,
   // result channel
   output      logic                               rsp_strobe,
   output      logic [hlm_pkg::EventWidth-1:0]     rsp_event_res,
   output      logic [hlm_pkg::NodeWidth-1:0]      rsp_event_node,
   output      logic                               rsp_status,
   output      logic                               rsp_alive,
   output      logic                               rsp_last,
   // configuration write port
   input  wire logic                               csr_write_en,
   input  wire logic [hlm_pkg::CsrIdxWidth-1:0]    csr_index,
   input  wire logic [hlm_pkg::CsrDataWidth-1:0]   csr_write_data
);

   localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int unsigned CW = $clog2(SLOTS + 1);
   localparam int unsigned TW = hlm_pkg::TimeWidth;
   localparam int unsigned MW = hlm_pkg::MsWidth;
   localparam int unsigned EW = hlm_pkg::EventWidth;
   localparam int unsigned NW = hlm_pkg::NodeWidth;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SWEEP_M,
      ST_SWEEP_W,
      ST_SWEEP_END
   } state_type;

   // ---------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------
   logic [MW-1:0]                  check_interval_ff;
   logic [MW-1:0]                  lease_ff;
   logic [MW-1:0]                  grace_ff;
   logic                           use_allow_ff;
   logic [hlm_pkg::MaskWidth-1:0]  allow_mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         check_interval_ff <= hlm_pkg::CHECK_INTERVAL_RESET;
         lease_ff          <= hlm_pkg::LEASE_RESET;
         grace_ff          <= hlm_pkg::GRACE_RESET;
         use_allow_ff      <= 1'b0;
         allow_mask_ff     <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            hlm_pkg::CSR_CHECK_INTERVAL: check_interval_ff <= csr_write_data;
            hlm_pkg::CSR_LEASE:          lease_ff          <= csr_write_data;
            hlm_pkg::CSR_GRACE:          grace_ff          <= csr_write_data;
            hlm_pkg::CSR_USE_ALLOW:      use_allow_ff      <= csr_write_data[0];
            hlm_pkg::CSR_ALLOW_MASK:
               allow_mask_ff <= csr_write_data[hlm_pkg::MaskWidth-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // state and latched transaction
   // ---------------------------------------------------------------
   state_type      state_ff;
   logic [CW-1:0]  cnt_ff;
   logic [SLOTS-1:0] master_valid_ff;
   logic [SLOTS-1:0] worker_valid_ff;
   // held-back sweep result, so the final one can carry rsp_last
   logic           pend_ff;
   logic [EW-1:0]  pend_event_ff;
   logic [NW-1:0]  pend_node_ff;

   logic [hlm_pkg::CmdWidth-1:0] cmd_ff;
   logic [NW-1:0]  node_ff;
   logic [TW-1:0]  now_ff;
   logic [TW-1:0]  beacon_ff;
   logic           ack_error_ff;
   logic           ack_allowed_ff;
   logic           ack_is_master_ff;
   logic           initial_alive_ff;

   logic           accept;
   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   // ---------------------------------------------------------------
   // slot tables: valid bits in flops, row contents in memories
   // ---------------------------------------------------------------
   hlm_pkg::master_row_type m_rd, m_wdata;
   hlm_pkg::worker_row_type w_rd, w_wdata;
   logic            m_we, w_we;
   logic [IW-1:0]   rd_addr, wr_addr;

   hlm_ram #(
      .WIDTH ($bits(hlm_pkg::master_row_type)),
      .DEPTH (SLOTS)
   ) u_master_ram (
      .clock   (clock),
      .wr_en   (m_we),
      .wr_addr (wr_addr),
      .wr_data (m_wdata),
      .rd_addr (rd_addr),
      .rd_data (m_rd)
   );

   hlm_ram #(
      .WIDTH ($bits(hlm_pkg::worker_row_type)),
      .DEPTH (SLOTS)
   ) u_worker_ram (
      .clock   (clock),
      .wr_en   (w_we),
      .wr_addr (wr_addr),
      .wr_data (w_wdata),
      .rd_addr (rd_addr),
      .rd_data (w_rd)
   );

   // slot addressed by the latched command, and slot evaluated in a sweep
   logic [IW-1:0] slot_idx;
   logic [IW-1:0] sweep_idx;
   logic          node_ok;
   logic          cnt_done;

   assign slot_idx  = IW'(node_ff);
   assign sweep_idx = IW'(cnt_ff - CW'(1));
   assign node_ok   = (32'(node_ff) < SLOTS);
   assign cnt_done  = (32'(cnt_ff) == SLOTS);

   // read address: the sweep pointer in the two sweep states, the requested slot otherwise
   always_comb begin
      case (state_ff)
         ST_SWEEP_M, ST_SWEEP_W: rd_addr = cnt_done ? '0 : IW'(cnt_ff);
         default:                rd_addr = IW'(req_node);
      endcase
   end

   // ---------------------------------------------------------------
   // per-command read-modify-write
   // ---------------------------------------------------------------
   logic            m_vld, w_vld;
   logic            ack_newer, ack_in_lease, ping_newer;
   logic [TW-1:0]   ack_age;
   logic [TW-1:0]   m_age, w_age;
   logic [TW:0]     m_lookahead;
   logic            m_lost, w_lost;

   logic            set_m_valid, clr_m_valid, set_w_valid;
   logic [EW-1:0]   ex_event;
   logic            ex_status, ex_alive;

   assign m_vld        = node_ok && master_valid_ff[slot_idx];
   assign w_vld        = node_ok && worker_valid_ff[slot_idx];
   assign ack_newer    = (beacon_ff > m_rd.ack_time);
   assign ack_age      = now_ff - beacon_ff;
   assign ack_in_lease = (now_ff > beacon_ff) && (ack_age <= TW'(lease_ff));
   assign ping_newer   = (now_ff > w_rd.recv_time);

   // sweep loss tests for the slot whose row was read last cycle
   assign m_age       = now_ff - m_rd.ack_time;
   assign m_lookahead = {1'b0, m_age} + (TW + 1)'(check_interval_ff);
   assign m_lost      = master_valid_ff[sweep_idx] && m_rd.alive &&
                        (now_ff > m_rd.ack_time) &&
                        (m_lookahead > (TW + 1)'(lease_ff));
   assign w_age       = now_ff - w_rd.recv_time;
   assign w_lost      = worker_valid_ff[sweep_idx] && w_rd.alive &&
                        (now_ff > w_rd.recv_time) && (w_age > TW'(grace_ff));

   always_comb begin
      m_we        = 1'b0;
      w_we        = 1'b0;
      m_wdata     = m_rd;
      w_wdata     = w_rd;
      wr_addr     = slot_idx;
      set_m_valid = 1'b0;
      clr_m_valid = 1'b0;
      set_w_valid = 1'b0;
      ex_event    = hlm_pkg::EV_NONE;
      ex_status   = 1'b0;
      ex_alive    = 1'b0;

      case (state_ff)
         ST_EXEC: begin
            if (node_ok) begin
               case (cmd_ff)
                  hlm_pkg::CMD_PING: begin
                     if (!w_vld) begin
                        if (use_allow_ff && !allow_mask_ff[node_ff]) begin
                           ex_event = hlm_pkg::EV_WORKER_REJ;
                        end else begin
                           w_we        = 1'b1;
                           w_wdata     = '{recv_time: now_ff, alive: 1'b1};
                           set_w_valid = 1'b1;
                           ex_event    = hlm_pkg::EV_WORKER_CONN;
                           ex_status   = 1'b1;
                           ex_alive    = 1'b1;
                        end
                     end else begin
                        ex_status = 1'b1;
                        ex_alive  = w_rd.alive;
                        if (ping_newer) begin
                           w_we     = 1'b1;
                           w_wdata  = '{recv_time: now_ff, alive: 1'b1};
                           ex_alive = 1'b1;
                           if (!w_rd.alive) begin
                              ex_event = hlm_pkg::EV_WORKER_CONN;
                           end
                        end
                     end
                  end
                  hlm_pkg::CMD_ACK: begin
                     if (m_vld) begin
                        ex_alive = m_rd.alive;
                        if (!ack_allowed_ff) begin
                           m_we             = 1'b1;
                           m_wdata.rejected = 1'b1;
                           ex_event         = hlm_pkg::EV_WORKER_REJ;
                        end else if (ack_newer) begin
                           ex_status = 1'b1;
                           if (!ack_error_ff && ack_is_master_ff) begin
                              m_we             = 1'b1;
                              m_wdata.ack_time = beacon_ff;
                              m_wdata.rejected = 1'b0;
                              if (!m_rd.alive && ack_in_lease) begin
                                 m_wdata.alive = 1'b1;
                                 ex_alive      = 1'b1;
                                 ex_event      = hlm_pkg::EV_MASTER_CONN;
                              end
                           end
                        end
                     end
                  end
                  hlm_pkg::CMD_REG_MASTER: begin
                     m_we = 1'b1;
                     if (!m_vld) begin
                        m_wdata     = '{ack_time: now_ff, alive: 1'b0, rejected: 1'b0};
                        set_m_valid = 1'b1;
                        ex_status   = 1'b1;
                     end else begin
                        m_wdata.rejected = 1'b0;
                        ex_alive         = m_rd.alive;
                     end
                  end
                  hlm_pkg::CMD_UNREG_MSTR: begin
                     if (m_vld) begin
                        clr_m_valid = 1'b1;
                        ex_status   = 1'b1;
                     end
                  end
                  hlm_pkg::CMD_REG_WORKER: begin
                     if (!w_vld) begin
                        w_we        = 1'b1;
                        w_wdata     = '{recv_time: now_ff, alive: initial_alive_ff};
                        set_w_valid = 1'b1;
                        ex_status   = 1'b1;
                        ex_alive    = initial_alive_ff;
                     end else begin
                        ex_alive = w_rd.alive;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SWEEP_M: begin
            wr_addr = sweep_idx;
            if (cnt_ff != '0 && m_lost) begin
               m_we          = 1'b1;
               m_wdata.alive = 1'b0;
            end
         end
         ST_SWEEP_W: begin
            wr_addr = sweep_idx;
            if (cnt_ff != '0 && w_lost) begin
               w_we          = 1'b1;
               w_wdata.alive = 1'b0;
            end
         end
         default: ;
      endcase
   end

   // a loss found in this sweep cycle
   logic          sweep_hit;
   logic [EW-1:0] sweep_event;

   always_comb begin
      sweep_hit   = 1'b0;
      sweep_event = hlm_pkg::EV_NONE;
      case (state_ff)
         ST_SWEEP_M: begin
            sweep_hit   = (cnt_ff != '0) && m_lost;
            sweep_event = hlm_pkg::EV_MASTER_LOST;
         end
         ST_SWEEP_W: begin
            sweep_hit   = (cnt_ff != '0) && w_lost;
            sweep_event = hlm_pkg::EV_WORKER_LOST;
         end
         default: ;
      endcase
   end

   // ---------------------------------------------------------------
   // control fsm and registered results
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         cnt_ff          <= '0;
         master_valid_ff <= '0;
         worker_valid_ff <= '0;
         pend_ff         <= 1'b0;
         rsp_strobe      <= 1'b0;
      end else begin
         rsp_strobe <= 1'b0;

         if (set_m_valid) begin
            master_valid_ff[slot_idx] <= 1'b1;
         end
         if (clr_m_valid) begin
            master_valid_ff[slot_idx] <= 1'b0;
         end
         if (set_w_valid) begin
            worker_valid_ff[slot_idx] <= 1'b1;
         end

         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  cnt_ff  <= '0;
                  pend_ff <= 1'b0;
                  state_ff <= (req_cmd == hlm_pkg::CMD_SWEEP) ? ST_SWEEP_M : ST_EXEC;
               end
            end
            ST_EXEC: begin
               rsp_strobe     <= 1'b1;
               rsp_event_res  <= ex_event;
               rsp_event_node <= node_ff;
               rsp_status     <= ex_status;
               rsp_alive      <= ex_alive;
               rsp_last       <= 1'b1;
               state_ff       <= ST_IDLE;
            end
            ST_SWEEP_M, ST_SWEEP_W: begin
               if (sweep_hit) begin
                  // release the previous loss, hold this one back
                  if (pend_ff) begin
                     rsp_strobe     <= 1'b1;
                     rsp_event_res  <= pend_event_ff;
                     rsp_event_node <= pend_node_ff;
                     rsp_status     <= 1'b1;
                     rsp_alive      <= 1'b0;
                     rsp_last       <= 1'b0;
                  end
                  pend_ff       <= 1'b1;
                  pend_event_ff <= sweep_event;
                  pend_node_ff  <= NW'(sweep_idx);
               end
               if (cnt_done) begin
                  cnt_ff   <= '0;
                  state_ff <= (state_ff == ST_SWEEP_M) ? ST_SWEEP_W : ST_SWEEP_END;
               end else begin
                  cnt_ff <= cnt_ff + CW'(1);
               end
            end
            ST_SWEEP_END: begin
               rsp_strobe     <= 1'b1;
               rsp_event_res  <= pend_ff ? pend_event_ff : hlm_pkg::EV_NONE;
               rsp_event_node <= pend_ff ? pend_node_ff : '0;
               rsp_status     <= pend_ff;
               rsp_alive      <= 1'b0;
               rsp_last       <= 1'b1;
               pend_ff        <= 1'b0;
               state_ff       <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // transaction payload capture
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff           <= req_cmd;
         node_ff          <= req_node;
         now_ff           <= req_now_ms;
         beacon_ff        <= req_beacon_time;
         ack_error_ff     <= req_ack_error;
         ack_allowed_ff   <= req_ack_allowed;
         ack_is_master_ff <= req_ack_is_master;
         initial_alive_ff <= req_initial_alive;
      end
   end

endmodule
`default_nettype wire

### rtl/hlm_ram.sv
`default_nettype none
module hlm_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                                clock,
   input  wire logic                                wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                    wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                    rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### tb/sv/tb_heartbeat_lease_monitor_top.sv
`timescale 1ns / 100ps

module tb_heartbeat_lease_monitor_top;
   import hlm_pkg::*;

   // command codes the block does not decode, they must give an empty result
   localparam logic [CmdWidth-1:0] CMD_UNUSED_LO = 3'd6;
   localparam logic [CmdWidth-1:0] CMD_UNUSED_HI = 3'd7;

   localparam logic [TimeWidth-1:0] TIME_MAX    = '1;
   localparam int                   CYCLE_LIMIT = 200000;
   localparam int                   PHASE_ITEMS = 96;

   // one command transaction as the block takes it
   typedef struct packed {
      logic [CmdWidth-1:0]  cmd;
      logic [NodeWidth-1:0] node;
      logic [TimeWidth-1:0] now_ms;
      logic [TimeWidth-1:0] beacon_time;
      logic                 ack_error;
      logic                 ack_allowed;
      logic                 ack_is_master;
      logic                 initial_alive;
   } lease_request_type;

   // one result transaction
   typedef struct packed {
      logic [EventWidth-1:0] event_res;
      logic [NodeWidth-1:0]  event_node;
      logic                  status;
      logic                  alive;
      logic                  last;
   } lease_event_type;

   // ---------------------------------------------------------------------
   // scoreboard: own copy of the slot tables and registers, predicts the
   // events of every accepted command and checks them in order
   // ---------------------------------------------------------------------
   class lease_scoreboard;
      logic [MsWidth-1:0]   sweep_period;
      logic [MsWidth-1:0]   lease_len;
      logic [MsWidth-1:0]   grace_len;
      logic                 use_allow;
      logic [MaskWidth-1:0] allow_bits;

      bit                   master_on    [DefaultSlots];
      bit                   master_up    [DefaultSlots];
      bit                   master_kicked[DefaultSlots];
      logic [TimeWidth-1:0] master_ack   [DefaultSlots];
      bit                   worker_on    [DefaultSlots];
      bit                   worker_up    [DefaultSlots];
      logic [TimeWidth-1:0] worker_seen  [DefaultSlots];

      lease_event_type      due_events[$];
      int                   mismatches;

      function new();
         sweep_period   = CHECK_INTERVAL_RESET;
         lease_len      = LEASE_RESET;
         grace_len      = GRACE_RESET;
         use_allow      = 1'b0;
         allow_bits     = '0;
         mismatches     = 0;
         for (int i = 0; i < DefaultSlots; i++) begin
            master_on[i]     = 1'b0;
            master_up[i]     = 1'b0;
            master_kicked[i] = 1'b0;
            master_ack[i]    = '0;
            worker_on[i]     = 1'b0;
            worker_up[i]     = 1'b0;
            worker_seen[i]   = '0;
         end
      endfunction

      function void set_reg(input logic [CsrIdxWidth-1:0] idx,
                            input logic [CsrDataWidth-1:0] data);
         case (idx)
            CSR_CHECK_INTERVAL: sweep_period   = data[MsWidth-1:0];
            CSR_LEASE:          lease_len      = data[MsWidth-1:0];
            CSR_GRACE:          grace_len      = data[MsWidth-1:0];
            CSR_USE_ALLOW:      use_allow      = data[0];
            CSR_ALLOW_MASK:     allow_bits     = data[MaskWidth-1:0];
            default: ;
         endcase
      endfunction

      function void push(input logic [EventWidth-1:0] ev, input logic [NodeWidth-1:0] nd,
                         input logic st, input logic al, input logic lst);
         lease_event_type e;
         e.event_res  = ev;
         e.event_node = nd;
         e.status     = st;
         e.alive      = al;
         e.last       = lst;
         due_events   = {due_events, e};
      endfunction

      function void note_command(input lease_request_type r);
         int                    n;
         int                    lost;
         logic [63:0]           lookahead;
         logic [EventWidth-1:0] ev;
         logic                  st;
         logic                  al;
         lease_event_type       tail;
         n    = int'(r.node);
         ev   = EV_NONE;
         st   = 1'b0;
         al   = 1'b0;
         lost = 0;
         if (r.cmd == CMD_SWEEP) begin
            // masters first, then workers, both in ascending slot order
            for (int i = 0; i < DefaultSlots; i++) begin
               if (master_on[i] && master_up[i] && r.now_ms > master_ack[i]) begin
                  lookahead = 64'(r.now_ms) + 64'(sweep_period) - 64'(master_ack[i]);
                  if (lookahead > 64'(lease_len)) begin
                     master_up[i] = 1'b0;
                     push(EV_MASTER_LOST, NodeWidth'(i), 1'b1, 1'b0, 1'b0);
                     lost++;
                  end
               end
            end
            for (int i = 0; i < DefaultSlots; i++) begin
               if (worker_on[i] && worker_up[i] && r.now_ms > worker_seen[i] &&
                   (r.now_ms - worker_seen[i]) > TimeWidth'(grace_len)) begin
                  worker_up[i] = 1'b0;
                  push(EV_WORKER_LOST, NodeWidth'(i), 1'b1, 1'b0, 1'b0);
                  lost++;
               end
            end
            if (lost == 0) begin
               push(EV_NONE, '0, 1'b0, 1'b0, 1'b1);
            end else begin
               tail       = due_events.pop_back();
               tail.last  = 1'b1;
               due_events = {due_events, tail};
            end
            return;
         end
         case (r.cmd)
            CMD_PING: begin
               if (!worker_on[n]) begin
                  if (use_allow && !allow_bits[n]) begin
                     ev = EV_WORKER_REJ;
                  end else begin
                     worker_on[n]   = 1'b1;
                     worker_seen[n] = r.now_ms;
                     worker_up[n]   = 1'b1;
                     ev             = EV_WORKER_CONN;
                     st             = 1'b1;
                  end
               end else begin
                  st = 1'b1;
                  if (r.now_ms > worker_seen[n]) begin
                     worker_seen[n] = r.now_ms;
                     if (!worker_up[n]) begin
                        worker_up[n] = 1'b1;
                        ev           = EV_WORKER_CONN;
                     end
                  end
               end
               al = worker_on[n] && worker_up[n];
            end
            CMD_ACK: begin
               if (!master_on[n]) begin
                  st = 1'b0;
               end else if (!r.ack_allowed) begin
                  master_kicked[n] = 1'b1;
                  ev               = EV_WORKER_REJ;
               end else if (r.beacon_time <= master_ack[n]) begin
                  st = 1'b0;
               end else begin
                  st = 1'b1;
                  if (!r.ack_error && r.ack_is_master) begin
                     master_ack[n]    = r.beacon_time;
                     master_kicked[n] = 1'b0;
                     if (!master_up[n] && r.now_ms > r.beacon_time &&
                         (r.now_ms - r.beacon_time) <= TimeWidth'(lease_len)) begin
                        master_up[n] = 1'b1;
                        ev           = EV_MASTER_CONN;
                     end
                  end
               end
               al = master_on[n] && master_up[n];
            end
            CMD_REG_MASTER: begin
               if (!master_on[n]) begin
                  master_on[n]  = 1'b1;
                  master_ack[n] = r.now_ms;
                  master_up[n]  = 1'b0;
                  st            = 1'b1;
               end
               master_kicked[n] = 1'b0;
               al               = master_up[n];
            end
            CMD_UNREG_MSTR: begin
               if (master_on[n]) begin
                  master_on[n]     = 1'b0;
                  master_up[n]     = 1'b0;
                  master_kicked[n] = 1'b0;
                  master_ack[n]    = '0;
                  st               = 1'b1;
               end
            end
            CMD_REG_WORKER: begin
               if (!worker_on[n]) begin
                  worker_on[n]   = 1'b1;
                  worker_seen[n] = r.now_ms;
                  worker_up[n]   = r.initial_alive;
                  st             = 1'b1;
               end
               al = worker_up[n];
            end
            default: ;
         endcase
         push(ev, r.node, st, al, 1'b1);
      endfunction

      function void check_result(input lease_event_type got);
         lease_event_type want;
         if (due_events.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t unexpected result ev=%0d node=%0d st=%0d alive=%0d last=%0d",
                        $time, got.event_res, got.event_node, got.status, got.alive,
                        got.last);
            return;
         end
         want = due_events.pop_front();
         if (got.event_res !== want.event_res || got.event_node !== want.event_node ||
             got.status !== want.status || got.alive !== want.alive ||
             got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t mismatch: want ev=%0d node=%0d st=%0d alive=%0d last=%0d, %s",
                        $time, want.event_res, want.event_node, want.status, want.alive,
                        want.last,
                        $sformatf("got ev=%0d node=%0d st=%0d alive=%0d last=%0d",
                                  got.event_res, got.event_node, got.status, got.alive,
                                  got.last));
         end
      endfunction
   endclass

   // ---------------------------------------------------------------------
   // signals, every input of the block known from time zero
   // ---------------------------------------------------------------------
   logic                    clock             = 1'b0;
   logic                    reset             = 1'b1;
   logic                    start             = 1'b0;
   logic                    busy;
   logic [CmdWidth-1:0]     req_cmd           = CMD_PING;
   logic [NodeWidth-1:0]    req_node          = '0;
   logic [TimeWidth-1:0]    req_now_ms        = '0;
   logic [TimeWidth-1:0]    req_beacon_time   = '0;
   logic                    req_ack_error     = 1'b0;
   logic                    req_ack_allowed   = 1'b0;
   logic                    req_ack_is_master = 1'b0;
   logic                    req_initial_alive = 1'b0;
   logic                    rsp_strobe;
   logic [EventWidth-1:0]   rsp_event_res;
   logic [NodeWidth-1:0]    rsp_event_node;
   logic                    rsp_status;
   logic                    rsp_alive;
   logic                    rsp_last;
   logic                    csr_write_en      = 1'b0;
   logic [CsrIdxWidth-1:0]  csr_index         = CSR_CHECK_INTERVAL;
   logic [CsrDataWidth-1:0] csr_write_data    = '0;

   lease_scoreboard         sb;
   int                      cycle_count       = 0;

   // stimulus state: a running wall clock, how far it may jump per command,
   // the previous send time given to each master, and whether the sender idles
   logic [63:0]             wall_ms           = 64'd0;
   int unsigned             step_max          = 1000;
   logic [TimeWidth-1:0]    prev_beacon[DefaultSlots];
   bit                      idle_enabled      = 1'b1;

   heartbeat_lease_monitor_top #(
      .SLOTS(DefaultSlots)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_cmd           (req_cmd),
      .req_node          (req_node),
      .req_now_ms        (req_now_ms),
      .req_beacon_time   (req_beacon_time),
      .req_ack_error     (req_ack_error),
      .req_ack_allowed   (req_ack_allowed),
      .req_ack_is_master (req_ack_is_master),
      .req_initial_alive (req_initial_alive),
      .rsp_strobe        (rsp_strobe),
      .rsp_event_res     (rsp_event_res),
      .rsp_event_node    (rsp_event_node),
      .rsp_status        (rsp_status),
      .rsp_alive         (rsp_alive),
      .rsp_last          (rsp_last),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   // 10 ns clock
   initial begin
      forever #5 clock = ~clock;
   end

   // watchdog: generous bound on the whole run, sweeps included
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // result monitor: the receiver cannot stall, so every strobe is a
   // transaction and is checked against the oldest predicted event
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1)
         sb.check_result({rsp_event_res, rsp_event_node, rsp_status, rsp_alive, rsp_last});
   end

   // 48 random bits
   function automatic logic [TimeWidth-1:0] rand48();
      return {16'($urandom), $urandom};
   endfunction

   // present one command, hold it until the block takes it, then predict;
   // a random gap in front puts idle cycles on every phase of the block
   task automatic issue(input lease_request_type r);
      if (idle_enabled && $urandom_range(0, 99) < 11) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start             <= 1'b1;
      req_cmd           <= r.cmd;
      req_node          <= r.node;
      req_now_ms        <= r.now_ms;
      req_beacon_time   <= r.beacon_time;
      req_ack_error     <= r.ack_error;
      req_ack_allowed   <= r.ack_allowed;
      req_ack_is_master <= r.ack_is_master;
      req_initial_alive <= r.initial_alive;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      sb.note_command(r);
   endtask

   task automatic send(input logic [CmdWidth-1:0] cmd, input logic [NodeWidth-1:0] node,
                       input logic [TimeWidth-1:0] now, input logic [TimeWidth-1:0] beacon,
                       input logic err, input logic allowed, input logic claims_master,
                       input logic init_alive);
      lease_request_type r;
      r.cmd           = cmd;
      r.node          = node;
      r.now_ms        = now;
      r.beacon_time   = beacon;
      r.ack_error     = err;
      r.ack_allowed   = allowed;
      r.ack_is_master = claims_master;
      r.initial_alive = init_alive;
      issue(r);
   endtask

   // drain: nothing pending and the block idle, plus a short margin
   task automatic settle();
      start <= 1'b0;
      while (sb.due_events.size() != 0 || busy !== 1'b0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CsrIdxWidth-1:0] idx,
                            input logic [CsrDataWidth-1:0] data);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      @(posedge clock);
      sb.set_reg(idx, data);
   endtask

   // register settings, time base and pacing for each random phase
   task automatic program_phase(input int phase);
      case (phase)
         1: begin
            // tight timing, allow list on with a random mask
            csr_write(CSR_CHECK_INTERVAL, 24'd1000);
            csr_write(CSR_LEASE, 24'd3000);
            csr_write(CSR_GRACE, 24'd4000);
            csr_write(CSR_USE_ALLOW, 24'd1);
            csr_write(CSR_ALLOW_MASK, 24'($urandom_range(1, 16'hFFFE)));
            step_max     = 1500;
            idle_enabled = 1'b1;
         end
         2: begin
            // zero lease and grace: everything expires at once
            csr_write(CSR_CHECK_INTERVAL, 24'd0);
            csr_write(CSR_LEASE, 24'd0);
            csr_write(CSR_GRACE, 24'd0);
            csr_write(CSR_USE_ALLOW, 24'd0);
            csr_write(CSR_ALLOW_MASK, 24'h00FFFF);
            wall_ms      = 64'h0000_1000_0000_0000 + 64'($urandom);
            step_max     = 20;
            idle_enabled = 1'b1;
         end
         3: begin
            // largest settings, sender never idles
            csr_write(CSR_CHECK_INTERVAL, 24'hFFFFFF);
            csr_write(CSR_LEASE, 24'hFFFFFF);
            csr_write(CSR_GRACE, 24'hFFFFFF);
            csr_write(CSR_USE_ALLOW, 24'd1);
            csr_write(CSR_ALLOW_MASK, 24'd0);
            wall_ms      = 64'h0000_2000_0000_0000 + (64'($urandom) << 8);
            step_max     = 6000000;
            idle_enabled = 1'b0;
         end
         4: begin
            csr_write(CSR_CHECK_INTERVAL, 24'($urandom_range(0, 5000)));
            csr_write(CSR_LEASE, 24'($urandom_range(0, 10000)));
            csr_write(CSR_GRACE, 24'($urandom_range(0, 12000)));
            csr_write(CSR_USE_ALLOW, 24'd0);
            csr_write(CSR_ALLOW_MASK, 24'($urandom_range(0, 16'hFFFF)));
            wall_ms      = 64'h0000_6000_0000_0000 + 64'(rand48() >> 4);
            step_max     = 3000;
            idle_enabled = 1'b1;
         end
         default: begin
            // random wide settings near the top of the time range
            csr_write(CSR_CHECK_INTERVAL, 24'($urandom));
            csr_write(CSR_LEASE, 24'($urandom));
            csr_write(CSR_GRACE, 24'($urandom));
            csr_write(CSR_USE_ALLOW, 24'($urandom_range(0, 1)));
            csr_write(CSR_ALLOW_MASK, 24'($urandom_range(0, 16'hFFFF)));
            wall_ms      = 64'h0000_FFF0_0000_0000 + 64'($urandom);
            step_max     = ((sb.lease_len > sb.grace_len ? sb.lease_len : sb.grace_len) >> 2)
                           + 50;
            idle_enabled = 1'b1;
         end
      endcase
      csr_write_en <= 1'b0;
   endtask

   // mostly well formed traffic on a rising clock, with some noise
   task automatic make_random(output lease_request_type r);
      int unsigned roll;
      logic [63:0] span;
      logic [31:0] back;
      roll            = $urandom_range(0, 99);
      r.node          = NodeWidth'($urandom_range(0, DefaultSlots - 1));
      r.ack_error     = ($urandom_range(0, 9) == 0);
      r.ack_allowed   = ($urandom_range(0, 9) != 0);
      r.ack_is_master = ($urandom_range(0, 6) != 0);
      r.initial_alive = 1'($urandom_range(0, 1));
      wall_ms         = wall_ms + 64'($urandom_range(0, step_max));
      if (wall_ms > 64'(TIME_MAX))
         wall_ms = 64'(TIME_MAX);
      r.now_ms        = wall_ms[TimeWidth-1:0];
      // a recent send time, within about one and a half leases
      span            = 64'(sb.lease_len) + 64'(sb.lease_len >> 1) + 64'd1;
      back            = $urandom_range(0, span[31:0]);
      r.beacon_time   = (r.now_ms > TimeWidth'(back)) ? r.now_ms - TimeWidth'(back) : '0;
      if (roll < 30) begin
         r.cmd = CMD_PING;
      end else if (roll < 58) begin
         r.cmd = CMD_ACK;
         case ($urandom_range(0, 9))
            0:       r.beacon_time = prev_beacon[r.node];                // repeat, stale
            1:       r.beacon_time = r.now_ms +
                                     TimeWidth'($urandom_range(1, 1000)); // from the future
            default: ;
         endcase
         prev_beacon[r.node] = r.beacon_time;
      end else if (roll < 66) begin
         r.cmd = CMD_SWEEP;
      end else if (roll < 76) begin
         r.cmd = CMD_REG_MASTER;
      end else if (roll < 80) begin
         r.cmd = CMD_UNREG_MSTR;
      end else if (roll < 88) begin
         r.cmd = CMD_REG_WORKER;
      end else begin
         // noise: any code, random flags and beacon; time stays sane on
         // commands that store it so the tables keep working
         r.cmd           = CmdWidth'($urandom_range(0, 7));
         r.beacon_time   = rand48();
         r.ack_error     = 1'($urandom_range(0, 1));
         r.ack_allowed   = 1'($urandom_range(0, 1));
         r.ack_is_master = 1'($urandom_range(0, 1));
         if (r.cmd != CMD_PING && r.cmd != CMD_REG_MASTER && r.cmd != CMD_REG_WORKER)
            r.now_ms = rand48();
      end
   endtask

   initial begin
      lease_request_type r;
      sb = new();
      for (int i = 0; i < DefaultSlots; i++)
         prev_beacon[i] = '0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part under reset register values
      send(CMD_SWEEP,      4'd0,  48'd0,     48'd0,     1'b0, 1'b0, 1'b0, 1'b0); // empty sweep
      send(CMD_ACK,        4'd0,  48'd100,   48'd50,    1'b0, 1'b1, 1'b1, 1'b0); // unknown master
      send(CMD_UNREG_MSTR, 4'd15, 48'd100,   48'd0,     1'b0, 1'b0, 1'b0, 1'b0); // not found
      send(CMD_REG_MASTER, 4'd0,  48'd1000,  48'd0,     1'b0, 1'b0, 1'b0, 1'b0);
      send(CMD_ACK,        4'd0,  48'd1200,  48'd1100,  1'b0, 1'b0, 1'b1, 1'b0); // refused
      send(CMD_REG_MASTER, 4'd0,  48'd1300,  48'd0,     1'b0, 1'b0, 1'b0, 1'b0); // re-register
      send(CMD_ACK,        4'd0,  48'd1400,  48'd1000,  1'b0, 1'b1, 1'b1, 1'b0); // stale
      send(CMD_ACK,        4'd0,  48'd2000,  48'd1500,  1'b1, 1'b1, 1'b1, 1'b0); // error
      send(CMD_ACK,        4'd0,  48'd2000,  48'd1600,  1'b0, 1'b1, 1'b0, 1'b0); // not master
      send(CMD_ACK,        4'd0,  48'd2000,  48'd1700,  1'b0, 1'b1, 1'b1, 1'b0); // connects
      send(CMD_PING,       4'd15, 48'd2000,  48'd0,     1'b0, 1'b0, 1'b0, 1'b0); // new worker
      send(CMD_PING,       4'd15, 48'd2000,  48'd0,     1'b0, 1'b0, 1'b0, 1'b0); // same time
      send(CMD_REG_WORKER, 4'd15, 48'd2100,  48'd0,     1'b0, 1'b0, 1'b0, 1'b1); // present
      send(CMD_REG_WORKER, 4'd3,  48'd2000,  48'd0,     1'b0, 1'b0, 1'b0, 1'b0); // starts dead
      send(CMD_PING,       4'd3,  48'd2500,  48'd0,     1'b0, 1'b0, 1'b0, 1'b0); // revives
      send(CMD_REG_WORKER, 4'd7,  48'd3000,  48'd0,     1'b0, 1'b0, 1'b0, 1'b1);
      send(CMD_SWEEP,      4'd0,  48'd20000, 48'd0,     1'b0, 1'b0, 1'b0, 1'b0); // many lost
      send(CMD_ACK,        4'd0,  48'd30000, 48'd19000, 1'b0, 1'b1, 1'b1, 1'b0); // too old
      send(CMD_ACK,        4'd0,  48'd30000, 48'd29500, 1'b0, 1'b1, 1'b1, 1'b0); // reconnects
      send(CMD_UNUSED_LO,  4'd5,  TIME_MAX,  TIME_MAX,  1'b1, 1'b1, 1'b1, 1'b1);
      send(CMD_UNUSED_HI,  4'd10, 48'd0,     48'd0,     1'b0, 1'b0, 1'b0, 1'b0);
      send(CMD_ACK,        4'd0,  TIME_MAX,  TIME_MAX,  1'b1, 1'b1, 1'b1, 1'b1); // error at top
      send(CMD_REG_MASTER, 4'd1,  TIME_MAX,  48'd0,     1'b0, 1'b0, 1'b0, 1'b0);
      send(CMD_ACK,        4'd1,  TIME_MAX,  TIME_MAX,  1'b0, 1'b1, 1'b1, 1'b0); // not newer
      send(CMD_SWEEP,      4'd15, TIME_MAX,  48'd0,     1'b0, 1'b0, 1'b0, 1'b0); // lookahead wrap
      send(CMD_UNREG_MSTR, 4'd1,  TIME_MAX,  48'd0,     1'b0, 1'b0, 1'b0, 1'b0);
      wall_ms = 64'd30000;

      // random phases, registers rewritten only while the block is idle
      for (int phase = 1; phase <= 5; phase++) begin
         settle();
         program_phase(phase);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            make_random(r);
            issue(r);
         end
      end

      // drain and let the last sweep finish
      start <= 1'b0;
      while (sb.due_events.size() != 0) @(posedge clock);
      repeat (2 * DefaultSlots + 8) @(posedge clock);

      if (sb.due_events.size() != 0)
         $display("%0d expected results never arrived", sb.due_events.size());
      if (sb.mismatches == 0 && sb.due_events.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

### sim.f
rtl/hlm_pkg.sv
rtl/hlm_ram.sv
rtl/heartbeat_lease_monitor_top.sv
tb/sv/tb_heartbeat_lease_monitor_top.sv
